// ===== hdl/aplcm_pkg.sv =====
// shared widths, constants and divider control types for the adjacent pair lcm stream unit
package aplcm_pkg;

   // operand width used by the arithmetic (8 to 32)
   localparam int VALUE_WIDTH = 16;

   // fixed field widths of the channels
   localparam int IN_W  = 16;
   localparam int RES_W = 32;

   // divider step counter and product widths
   localparam int CNT_W  = $clog2(VALUE_WIDTH);
   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int EXT_W  = (PROD_W > RES_W) ? PROD_W : RES_W + 1;

   localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [VALUE_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/aplcm_if.sv =====
// valid/ready channel interfaces for the request and response items
interface aplcm_req_if import aplcm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] value;
   logic            list_end;

   modport source (output valid, output value, output list_end, input ready);
   modport sink   (input valid, input value, input list_end, output ready);
endinterface

interface aplcm_rsp_if import aplcm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] result_value;
   logic             run_last;
   logic             list_last;

   modport source (output valid, output result_value, output run_last, output list_last,
                   input ready);
   modport sink   (input valid, input result_value, input run_last, input list_last,
                   output ready);
endinterface

// ===== hdl/aplcm_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module aplcm_divider import aplcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] dvs_ff, dvs_in;

   logic [VALUE_WIDTH:0]   rem_sh;
   logic [VALUE_WIDTH:0]   diff;
   logic                   ge;

   // shift in next dividend bit and try subtract
   assign rem_sh = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = ~diff[VALUE_WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hdl/adjacent_pair_lcm_stream_unit.sv =====
// top level: sequencer for the adjacent pair lcm stream around the shared divider
//
// usage
//   req_if carries one list element (value) per item with list_end on the last one.
//   rsp_if returns, per list, a0, lcm(a0,a1), ..., lcm(a[n-2],a[n-1]), a[n-1].
//   run_last marks the last response item caused by a request item, list_last
//   marks the final response item of a list. a pair holding a zero gives 0, and
//   an lcm above 32 bits saturates at all ones.
// timing
//   one request item at a time: req_if.ready is high only while the unit idles.
//   an echo (first element of a list, or a pair with a zero) is valid in the cycle
//   after accept. an lcm reaches its first response only after each euclid
//   remainder step and then the final quotient have run through the one
//   bit-per-cycle divider, followed by a multiply and a clamp.
//   a final element adds one more response item in the cycle after the first is taken.
// reset
//   synchronous reset clears the sequencer and starts a new list.
// stalls
//   a response item holds in the output register until rsp_if.ready is high;
//   no new request item is taken until all its responses are delivered.
module adjacent_pair_lcm_stream_unit import aplcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   aplcm_req_if.sink     req_if,
   aplcm_rsp_if.source   rsp_if
);

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_GCD_START = 4'd1;
   localparam logic [3:0] ST_GCD_WAIT  = 4'd2;
   localparam logic [3:0] ST_LCM_START = 4'd3;
   localparam logic [3:0] ST_LCM_WAIT  = 4'd4;
   localparam logic [3:0] ST_MULT      = 4'd5;
   localparam logic [3:0] ST_CLAMP     = 4'd6;
   localparam logic [3:0] ST_OUT1      = 4'd7;
   localparam logic [3:0] ST_OUT2      = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic                   have_ff, have_in;     // an element of this list was seen
   logic [VALUE_WIDTH-1:0] prev_ff, prev_in;     // previous element of this list
   logic [VALUE_WIDTH-1:0] val_ff, val_in;       // current element
   logic                   fin_ff, fin_in;       // current element ends the list
   logic [VALUE_WIDTH-1:0] gx_ff, gx_in;         // euclid pair
   logic [VALUE_WIDTH-1:0] gy_ff, gy_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;     // previous / gcd
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [RES_W-1:0]       res_ff, res_in;       // first response value

   logic [VALUE_WIDTH-1:0] val_acc;
   logic [EXT_W-1:0]       prod_ext;
   logic                   req_take;
   logic                   rsp_take;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   aplcm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // only the low operand bits take part
   assign val_acc  = VALUE_WIDTH'(req_if.value);

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_if.valid && rsp_if.ready;

   // the divider serves both euclid remainders and the final quotient
   assign div_req.start    = (state_ff == ST_GCD_START) || (state_ff == ST_LCM_START);
   assign div_req.dividend = (state_ff == ST_LCM_START) ? prev_ff : gx_ff;
   assign div_req.divisor  = (state_ff == ST_LCM_START) ? gx_ff : gy_ff;

   assign prod_ext = EXT_W'(prod_ff);

   always_comb begin
      state_in = state_ff;
      have_in  = have_ff;
      prev_in  = prev_ff;
      val_in   = val_ff;
      fin_in   = fin_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      quot_in  = quot_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               val_in = val_acc;
               fin_in = req_if.list_end;
               gx_in  = prev_ff;
               gy_in  = val_acc;
               if (!have_ff) begin
                  // first element of a list is echoed
                  res_in   = RES_W'(val_acc);
                  state_in = ST_OUT1;
               end else if ((prev_ff == '0) || (val_acc == '0)) begin
                  // pair with a zero
                  res_in   = '0;
                  state_in = ST_OUT1;
               end else begin
                  state_in = ST_GCD_START;
               end
            end
         end
         ST_GCD_START: begin
            state_in = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (div_rsp.done) begin
               gx_in = gy_ff;
               gy_in = div_rsp.remainder;
               // zero remainder: gx holds the gcd
               state_in = (div_rsp.remainder == '0) ? ST_LCM_START : ST_GCD_START;
            end
         end
         ST_LCM_START: begin
            state_in = ST_LCM_WAIT;
         end
         ST_LCM_WAIT: begin
            if (div_rsp.done) begin
               quot_in  = div_rsp.quotient;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(quot_ff) * PROD_W'(val_ff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            res_in   = (prod_ext > EXT_W'(RES_MAX)) ? RES_MAX : prod_ext[RES_W-1:0];
            state_in = ST_OUT1;
         end
         ST_OUT1: begin
            if (rsp_take) begin
               if (fin_ff) begin
                  state_in = ST_OUT2;
               end else begin
                  prev_in  = val_ff;
                  have_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT2: begin
            if (rsp_take) begin
               // list closed, next element starts a new one
               prev_in  = '0;
               have_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_ff  <= 1'b0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         have_ff  <= have_in;
         prev_ff  <= prev_in;
      end
      val_ff  <= val_in;
      fin_ff  <= fin_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      quot_ff <= quot_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   // response drive: first item from res, closing echo from the element
   assign rsp_if.valid        = (state_ff == ST_OUT1) || (state_ff == ST_OUT2);
   assign rsp_if.result_value = (state_ff == ST_OUT2) ? RES_W'(val_ff) : res_ff;
   assign rsp_if.run_last     = (state_ff == ST_OUT2) || !fin_ff;
   assign rsp_if.list_last    = (state_ff == ST_OUT2);

endmodule

// ===== hdl/aplcm_checker.sv =====
// port level checker for the adjacent pair lcm stream unit and its bind
module aplcm_checker import aplcm_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [RES_W-1:0] rsp_result_value,
   input logic             rsp_run_last,
   input logic             rsp_list_last
);

   // no new item taken while a response is pending
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while response pending");

   // an accepted item takes the unit out of idle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after accept");

   // first of two responses is followed at once by the closing item
   a_close_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> (rsp_valid && rsp_list_last))
      else $error("closing response missing");

   // reset leaves no response pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("stalled response changed");

endmodule

bind adjacent_pair_lcm_stream_unit aplcm_checker u_aplcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.result_value),
   .rsp_run_last     (rsp_if.run_last),
   .rsp_list_last    (rsp_if.list_last)
);

// ===== test/adjacent_pair_lcm_stream_unit_check.sv =====
// response predictor and comparator for the adjacent pair lcm stream unit
`timescale 1ns / 100ps

module adjacent_pair_lcm_stream_unit_check import aplcm_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   aplcm_req_if  req_mon,
   aplcm_rsp_if  rsp_mon,
   output int    error_count,
   output int    results_pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [RES_W-1:0] result_value;
      logic             run_last;
      logic             list_last;
   } lcm_item_type;

   lcm_item_type           lcm_due[$];
   logic [VALUE_WIDTH-1:0] prev_elem;
   logic                   have_prev;

   // euclid gcd, then (a / g) * b, saturated to the result width
   function automatic logic [RES_W-1:0] pair_lcm(input logic [VALUE_WIDTH-1:0] a,
                                                 input logic [VALUE_WIDTH-1:0] b);
      longint unsigned x, y, r, prod;
      if (a == '0 || b == '0) return '0;
      x = 64'(a);
      y = 64'(b);
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      prod = (64'(a) / x) * 64'(b);
      if (prod > 64'(RES_MAX)) return RES_MAX;
      return prod[RES_W-1:0];
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   // append one expected result at the tail
   task automatic queue_result(input lcm_item_type entry);
      lcm_due = {lcm_due, entry};
   endtask

   always @(posedge clock) begin
      lcm_item_type           want;
      logic [VALUE_WIDTH-1:0] elem;
      logic [RES_W-1:0]       head_val;
      if (reset) begin
         lcm_due.delete();
         prev_elem       <= '0;
         have_prev       <= 1'b0;
         results_pending <= 0;
      end else begin
         // results first, so an item taken at this edge cannot cover a stray result
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (lcm_due.size() == 0) begin
               flag_error($sformatf("unexpected result: value %0d run_last %0b list_last %0b",
                                    rsp_mon.result_value, rsp_mon.run_last,
                                    rsp_mon.list_last));
            end else begin
               want = lcm_due.pop_front();
               if (rsp_mon.result_value !== want.result_value)
                  flag_error($sformatf("result_value: expected %0d, got %0d",
                                       want.result_value, rsp_mon.result_value));
               if (rsp_mon.run_last !== want.run_last)
                  flag_error($sformatf("run_last: expected %0b, got %0b (value %0d)",
                                       want.run_last, rsp_mon.run_last, want.result_value));
               if (rsp_mon.list_last !== want.list_last)
                  flag_error($sformatf("list_last: expected %0b, got %0b (value %0d)",
                                       want.list_last, rsp_mon.list_last, want.result_value));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            elem     = VALUE_WIDTH'(req_mon.value);
            head_val = have_prev ? pair_lcm(prev_elem, elem) : RES_W'(elem);
            if (req_mon.list_end) begin
               queue_result('{head_val, 1'b0, 1'b0});
               queue_result('{RES_W'(elem), 1'b1, 1'b1});
               prev_elem <= '0;
               have_prev <= 1'b0;
            end else begin
               queue_result('{head_val, 1'b1, 1'b0});
               prev_elem <= elem;
               have_prev <= 1'b1;
            end
         end
         results_pending <= lcm_due.size();
      end
   end

endmodule

// ===== test/adjacent_pair_lcm_stream_unit_test.sv =====
// stimulus, flow control and verdict for the adjacent pair lcm stream unit
`timescale 1ns / 100ps

module adjacent_pair_lcm_stream_unit_test;
   import aplcm_pkg::*;

   // long response hold-off, well past one lcm so the unit backs up into its input
   localparam int     RSP_HOLD_CYCLES = 600;
   // random items per idling phase; four phases plus the directed lists give ~1850
   localparam int     PHASE_ITEMS     = 456;
   // quiet time after the last result, about one worst-case lcm at 16 bits
   localparam int     SETTLE_CYCLES   = 500;
   // hard time limit, several times the slowest legal run
   localparam longint LIMIT_NS        = 72_000_000;

   logic clock = 1'b0;
   logic reset;

   // idling knobs, in percent of cycles
   int   send_idle_pct;
   int   rsp_stall_pct;
   bit   rsp_hold_req;

   int   error_count;
   int   results_pending;

   logic [IN_W-1:0] last_elem;

   aplcm_req_if req_ch ();
   aplcm_rsp_if rsp_ch ();

   adjacent_pair_lcm_stream_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   adjacent_pair_lcm_stream_unit_check lcm_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop in case the unit hangs
   initial begin
      #LIMIT_NS;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls per phase, plus one long hold-off counted here
   initial begin : receiver
      int  hold_left;
      bit  hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !hold_used) begin
            hold_left = RSP_HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // offer one list element; valid stays high after the handshake so the next
   // item can follow back to back without lowering and raising in one step
   task automatic offer_elem(input logic [IN_W-1:0] elem, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.value    <= elem;
      req_ch.list_end <= fin;
      do @(posedge clock); while (!req_ch.ready);
      last_elem = elem;
   endtask

   // stop sending and wait until every expected result has been taken
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // element mix: small values for short euclid runs, full-range values to
   // toggle every bit, zeros, extremes, and values tied to the previous one
   function automatic logic [IN_W-1:0] pick_elem(input logic [IN_W-1:0] prev);
      int sel;
      sel = $urandom_range(99);
      if (sel < 30)      return IN_W'($urandom_range(1, 255));
      else if (sel < 60) return IN_W'($urandom);
      else if (sel < 67) return '0;
      else if (sel < 72) return '1;
      else if (sel < 78) return IN_W'(1) << $urandom_range(IN_W - 1);
      else if (sel < 86) return prev;
      else               return prev * IN_W'($urandom_range(2, 7));
   endfunction

   // random lists of mostly short length, the last one cut to land on n_items
   task automatic send_random_lists(input int n_items);
      int left, len;
      left = n_items;
      while (left > 0) begin
         len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
         if (len > left) len = left;
         for (int k = 0; k < len; k++) offer_elem(pick_elem(last_elem), k == len - 1);
         left -= len;
      end
   endtask

   initial begin
      last_elem        = '0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.value    <= '0;
      req_ch.list_end <= 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      rsp_hold_req     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lists, no idling
      // list of one at the top of the range: echoed twice
      offer_elem(16'hffff, 1'b1);
      // list of one holding zero
      offer_elem(16'h0000, 1'b1);
      // zeros inside a list: every pair with a zero gives zero
      offer_elem(16'h0000, 1'b0);
      offer_elem(16'd5,    1'b0);
      offer_elem(16'h0000, 1'b0);
      offer_elem(16'd7,    1'b1);
      // largest coprime pair, widest product
      offer_elem(16'hffff, 1'b0);
      offer_elem(16'hfffe, 1'b0);
      offer_elem(16'd65521, 1'b0);
      offer_elem(16'd1,    1'b1);
      // consecutive fibonacci numbers: longest euclid run at 16 bits
      offer_elem(16'd46368, 1'b0);
      offer_elem(16'd28657, 1'b0);
      offer_elem(16'd12,   1'b1);
      // equal neighbors and divisible pairs
      offer_elem(16'd1,    1'b0);
      offer_elem(16'd1,    1'b1);
      offer_elem(16'h8000, 1'b0);
      offer_elem(16'h4000, 1'b0);
      offer_elem(16'h4000, 1'b0);
      offer_elem(16'hffff, 1'b1);
      // alternating bit patterns
      offer_elem(16'haaaa, 1'b0);
      offer_elem(16'h5555, 1'b1);
      offer_elem(16'd1,    1'b1);
      wait_drain();

      // phase 1: no idling, with one long response hold-off so the input backs up
      rsp_hold_req = 1'b1;
      send_random_lists(PHASE_ITEMS);
      wait_drain();

      // phase 2: sender mostly idle
      send_idle_pct = 84;
      send_random_lists(PHASE_ITEMS);
      wait_drain();

      // phase 3: receiver mostly stalling
      send_idle_pct = 0;
      rsp_stall_pct = 84;
      send_random_lists(PHASE_ITEMS);
      wait_drain();

      // phase 4: light idling on both sides
      send_idle_pct = 16;
      rsp_stall_pct = 16;
      send_random_lists(PHASE_ITEMS);
      wait_drain();

      // watch for stray results before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && results_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
